// ===== src/hls_pkg.sv =====
// Shared types and constants for the hostname label sanitizer.
// Used by the front, queue, back and top-level modules.
package hls_pkg;

    localparam logic [1:0] KIND_PREFIX = 2'd0;
    localparam logic [1:0] KIND_SUFFIX = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [7:0] DASH_CHAR = 8'h2d;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam int REG_LIMIT_IDX = 0;

    typedef struct packed {
        logic       is_end;
        logic       suffix;
        logic       alnum;
        logic [7:0] ch;
    } item_t;

endpackage

// ===== src/hls_front.sv =====
// Input stage: accepts stream words, classifies and lower-cases characters.
// Depends on hls_pkg; feeds hls_queue.
module hls_front
    import hls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic [1:0] s_tuser,   // [1:0] kind
    output logic       item_vld,
    output item_t      item,
    input  logic       queue_full
);

    logic  front_vld_reg;
    logic  front_vld_next;
    item_t item_reg;
    item_t item_next;
    logic  is_lower;
    logic  is_upper;
    logic  is_digit;

    always_comb begin
        is_lower = (s_tdata >= 8'h61) && (s_tdata <= 8'h7a);
        is_upper = (s_tdata >= 8'h41) && (s_tdata <= 8'h5a);
        is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);
        item_next.is_end = (s_tuser == KIND_END);
        item_next.suffix = (s_tuser == KIND_SUFFIX);
        item_next.alnum  = is_lower || is_upper || is_digit;
        if (is_upper) begin
            item_next.ch = s_tdata + CASE_OFFSET;
        end else if (is_lower || is_digit) begin
            item_next.ch = s_tdata;
        end else begin
            item_next.ch = DASH_CHAR;
        end
    end

    assign s_tready = !front_vld_reg || !queue_full;

    always_comb begin
        if (s_tready) begin
            front_vld_next = s_tvalid && (s_tuser != KIND_NONE);
        end else begin
            front_vld_next = front_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= 1'b0;
        end else begin
            front_vld_reg <= front_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

    assign item_vld = front_vld_reg;
    assign item     = item_reg;

endmodule

// ===== src/hls_queue.sv =====
// Short queue of classified words between the front and back stages.
// Depends on hls_pkg.
module hls_queue
    import hls_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_vld,
    output item_t head
);

    item_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW:0]      count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_vld = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && head_vld;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/hls_back.sv =====
// Back stage: label state, dash folding, separator and length cap, output register.
// Depends on hls_pkg; reads classified words from hls_queue.
module hls_back
    import hls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [5:0] lim,
    input  logic       head_vld,
    input  item_t      head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    logic       in_sfx_reg, in_sfx_next;
    logic [5:0] wc_reg, wc_next;
    logic [5:0] plen_reg, plen_next;
    logic       dp_reg, dp_next;
    logic       seg_reg, seg_next;
    logic       pend_vld_reg, pend_vld_next;
    logic [7:0] pend_char_reg, pend_char_next;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_has_reg, out_has_next;
    logic       out_last_reg, out_last_next;
    logic       out_free;
    logic [6:0] wc;
    logic [6:0] lim_x;
    logic       emit_sep;
    logic       emit_ch;

    assign out_free = !out_vld_reg || m_tready;
    assign lim_x    = {1'b0, lim};

    always_comb begin
        in_sfx_next    = in_sfx_reg;
        wc_next        = wc_reg;
        plen_next      = plen_reg;
        dp_next        = dp_reg;
        seg_next       = seg_reg;
        pend_vld_next  = pend_vld_reg;
        pend_char_next = pend_char_reg;
        out_vld_next   = out_vld_reg;
        out_char_next  = out_char_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        wc             = {1'b0, wc_reg};
        emit_sep       = 1'b0;
        emit_ch        = 1'b0;
        if (out_free) begin
            out_vld_next = 1'b0;
            if (pend_vld_reg) begin
                out_vld_next  = 1'b1;
                out_char_next = pend_char_reg;
                out_has_next  = 1'b1;
                out_last_next = 1'b0;
                pend_vld_next = 1'b0;
            end else if (head_vld) begin
                pop = 1'b1;
                if (head.is_end) begin
                    out_vld_next  = 1'b1;
                    out_char_next = 8'h00;
                    out_has_next  = 1'b0;
                    out_last_next = 1'b1;
                    in_sfx_next   = 1'b0;
                    wc_next       = '0;
                    plen_next     = '0;
                    dp_next       = 1'b0;
                    seg_next      = 1'b0;
                end else begin
                    if (head.suffix && !in_sfx_reg) begin
                        in_sfx_next = 1'b1;
                        plen_next   = wc_reg;
                        seg_next    = 1'b0;
                        dp_next     = 1'b0;
                    end
                    if (!head.alnum) begin
                        if (seg_next) begin
                            dp_next = 1'b1;
                        end
                    end else begin
                        if (!seg_next) begin
                            seg_next = 1'b1;
                            dp_next  = 1'b0;
                            if (in_sfx_next && (plen_next != '0)) begin
                                if (({1'b0, plen_next} + 7'd1) < lim_x) begin
                                    emit_sep = 1'b1;
                                    wc       = wc + 7'd1;
                                end else begin
                                    wc = lim_x;
                                end
                            end
                        end else if (dp_next) begin
                            dp_next = 1'b0;
                            if (wc < lim_x) begin
                                emit_sep = 1'b1;
                                wc       = wc + 7'd1;
                            end
                        end
                        if (wc < lim_x) begin
                            emit_ch = 1'b1;
                            wc      = wc + 7'd1;
                        end
                    end
                    wc_next       = wc[5:0];
                    out_vld_next  = emit_sep || emit_ch;
                    out_has_next  = 1'b1;
                    out_last_next = 1'b0;
                    out_char_next = emit_sep ? DASH_CHAR : head.ch;
                    if (emit_sep && emit_ch) begin
                        pend_vld_next  = 1'b1;
                        pend_char_next = head.ch;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sfx_reg   <= 1'b0;
            wc_reg       <= '0;
            plen_reg     <= '0;
            dp_reg       <= 1'b0;
            seg_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            in_sfx_reg   <= in_sfx_next;
            wc_reg       <= wc_next;
            plen_reg     <= plen_next;
            dp_reg       <= dp_next;
            seg_reg      <= seg_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/hostname_label_sanitizer_unit.sv =====
// Path: a word accepted at the input passes the input register, the queue and
// the output register before its first result word is valid; a separator leaves
// ahead of the character that follows it, which waits in a pending register.
// Throughput: one word per cycle while m_tready holds; a word that yields two
// results stalls the back stage; the four-entry queue absorbs the difference.
// Reset: synchronous, active low; clears label state, the limit returns to 63.
module hostname_label_sanitizer_unit
    import hls_pkg::*;
#(
    parameter int LENGTH_CAP = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tuser,   // [0] has_char
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [5:0] MAX_LIM = 6'(LENGTH_CAP);
    localparam logic [2:0] ADDR_LIMIT = 3'(4 * REG_LIMIT_IDX);

    logic [5:0] limit_reg;
    logic [5:0] lim;
    logic       item_vld;
    item_t      item;
    logic       queue_full;
    logic       pop;
    logic       head_vld;
    item_t      head;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LIMIT) ? {26'd0, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 6'd63;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_LIMIT)) begin
            limit_reg <= pwdata[5:0];
        end
    end

    assign lim = (limit_reg < MAX_LIM) ? limit_reg : MAX_LIM;

    hls_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_vld   (item_vld),
        .item       (item),
        .queue_full (queue_full)
    );

    hls_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_vld),
        .push_item (item),
        .full      (queue_full),
        .pop       (pop),
        .head_vld  (head_vld),
        .head      (head)
    );

    hls_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lim      (lim),
        .head_vld (head_vld),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
